/* rtl/core/tdpe_pkg.sv */
`timescale 1ns / 1ps

package tdpe_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_INDEX_DEF  = 1048575;
	localparam int FIELD_W        = 32;
	localparam int STEP_W         = 5;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_BEAT,
		C_KIND1,
		C_LT2,
		C_EQ2,
		C_EVEN,
		C_SQ_GT,
		C_MOD_BUSY,
		C_REM_ZERO,
		C_IDX_BAD,
		C_IDX_ZERO,
		C_FOUND_EQ,
		C_AT_LIMIT
	} cond_t;

	typedef enum logic [2:0] {
		E_NONE,
		E_TEST_PASS,
		E_TEST_FAIL,
		E_NTH,
		E_TWO,
		E_BAD
	} emit_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		logic  accept;
		logic  ld_cand3;
		logic  init_div;
		logic  start_mod;
		logic  next_div;
		logic  next_cand;
		logic  inc_found;
		emit_t emit;
	} uword_t;

	typedef struct packed {
		logic busy;
		logic rem_zero;
	} mod_status_t;

	localparam step_t S_WAIT      = step_t'(0);
	localparam step_t S_DISPATCH  = step_t'(1);
	localparam step_t S_TEST      = step_t'(2);
	localparam step_t S_TEST_EQ2  = step_t'(3);
	localparam step_t S_TEST_EVEN = step_t'(4);
	localparam step_t S_INIT_DIV  = step_t'(5);
	localparam step_t S_LOOP      = step_t'(6);
	localparam step_t S_START_MOD = step_t'(7);
	localparam step_t S_MOD_WAIT  = step_t'(8);
	localparam step_t S_MOD_CHECK = step_t'(9);
	localparam step_t S_LOOP_BACK = step_t'(10);
	localparam step_t S_PRIME     = step_t'(11);
	localparam step_t S_EMIT_PASS = step_t'(12);
	localparam step_t S_COMPOSITE = step_t'(13);
	localparam step_t S_EMIT_FAIL = step_t'(14);
	localparam step_t S_NTH       = step_t'(15);
	localparam step_t S_NTH_ZERO  = step_t'(16);
	localparam step_t S_NTH_INIT  = step_t'(17);
	localparam step_t S_NTH_FOUND = step_t'(18);
	localparam step_t S_NTH_COUNT = step_t'(19);
	localparam step_t S_NTH_NEXT  = step_t'(20);
	localparam step_t S_NTH_STEP  = step_t'(21);
	localparam step_t S_EMIT_NTH  = step_t'(22);
	localparam step_t S_EMIT_TWO  = step_t'(23);
	localparam step_t S_EMIT_BAD  = step_t'(24);

	function automatic uword_t ucode(step_t s);
		uword_t w;
		w.cond      = C_NEVER;
		w.target    = S_WAIT;
		w.accept    = 1'b0;
		w.ld_cand3  = 1'b0;
		w.init_div  = 1'b0;
		w.start_mod = 1'b0;
		w.next_div  = 1'b0;
		w.next_cand = 1'b0;
		w.inc_found = 1'b0;
		w.emit      = E_NONE;
		unique case (s)
			S_WAIT: begin
				w.accept = 1'b1;
				w.cond   = C_NO_BEAT;
				w.target = S_WAIT;
			end
			S_DISPATCH: begin
				w.cond   = C_KIND1;
				w.target = S_NTH;
			end
			S_TEST: begin
				w.cond   = C_LT2;
				w.target = S_COMPOSITE;
			end
			S_TEST_EQ2: begin
				w.cond   = C_EQ2;
				w.target = S_PRIME;
			end
			S_TEST_EVEN: begin
				w.cond   = C_EVEN;
				w.target = S_COMPOSITE;
			end
			S_INIT_DIV: begin
				w.init_div = 1'b1;
			end
			S_LOOP: begin
				w.cond   = C_SQ_GT;
				w.target = S_PRIME;
			end
			S_START_MOD: begin
				w.start_mod = 1'b1;
			end
			S_MOD_WAIT: begin
				w.cond   = C_MOD_BUSY;
				w.target = S_MOD_WAIT;
			end
			S_MOD_CHECK: begin
				w.cond     = C_REM_ZERO;
				w.target   = S_COMPOSITE;
				w.next_div = 1'b1;
			end
			S_LOOP_BACK: begin
				w.cond   = C_ALWAYS;
				w.target = S_LOOP;
			end
			S_PRIME: begin
				w.cond   = C_KIND1;
				w.target = S_NTH_FOUND;
			end
			S_EMIT_PASS: begin
				w.emit   = E_TEST_PASS;
				w.cond   = C_ALWAYS;
				w.target = S_WAIT;
			end
			S_COMPOSITE: begin
				w.cond   = C_KIND1;
				w.target = S_NTH_NEXT;
			end
			S_EMIT_FAIL: begin
				w.emit   = E_TEST_FAIL;
				w.cond   = C_ALWAYS;
				w.target = S_WAIT;
			end
			S_NTH: begin
				w.cond   = C_IDX_BAD;
				w.target = S_EMIT_BAD;
			end
			S_NTH_ZERO: begin
				w.cond   = C_IDX_ZERO;
				w.target = S_EMIT_TWO;
			end
			S_NTH_INIT: begin
				w.ld_cand3 = 1'b1;
				w.cond     = C_ALWAYS;
				w.target   = S_TEST;
			end
			S_NTH_FOUND: begin
				w.cond   = C_FOUND_EQ;
				w.target = S_EMIT_NTH;
			end
			S_NTH_COUNT: begin
				w.inc_found = 1'b1;
			end
			S_NTH_NEXT: begin
				w.cond   = C_AT_LIMIT;
				w.target = S_EMIT_BAD;
			end
			S_NTH_STEP: begin
				w.next_cand = 1'b1;
				w.cond      = C_ALWAYS;
				w.target    = S_TEST;
			end
			S_EMIT_NTH: begin
				w.emit   = E_NTH;
				w.cond   = C_ALWAYS;
				w.target = S_WAIT;
			end
			S_EMIT_TWO: begin
				w.emit   = E_TWO;
				w.cond   = C_ALWAYS;
				w.target = S_WAIT;
			end
			S_EMIT_BAD: begin
				w.emit   = E_BAD;
				w.cond   = C_ALWAYS;
				w.target = S_WAIT;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = S_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/tdpe_req_if.sv */
`timescale 1ns / 1ps

interface tdpe_req_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [tdpe_pkg::FIELD_W-1:0] operand_value;

	modport source (output valid, kind, operand_value, input ready);
	modport sink (input valid, kind, operand_value, output ready);
endinterface

/* rtl/core/tdpe_rsp_if.sv */
`timescale 1ns / 1ps

interface tdpe_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         is_prime_flag;
	logic [tdpe_pkg::FIELD_W-1:0] prime_value;
	logic                         index_too_large;

	modport source (output valid, is_prime_flag, prime_value, index_too_large, input ready);
	modport sink (input valid, is_prime_flag, prime_value, index_too_large, output ready);
endinterface

/* rtl/core/trial_division_prime_engine.sv */
`timescale 1ns / 1ps
// Trial-division prime engine.
// Request channel (req): kind 0 tests operand_value for primality, kind 1 asks
// for the prime at zero-based index operand_value. Response channel (rsp):
// one beat per request with is_prime_flag, prime_value and index_too_large.
// Both channels use valid/ready; a beat moves when both are high.
// A small microcode program sequences the work, one control word per cycle
// except while it holds on a full output register. Each odd trial divisor
// goes through the bit-serial remainder unit, which is VB bits wide, where VB
// is min(VALUE_BITS, 32). A kind 1 search repeats a kind 0 test for every odd
// candidate up to the requested prime. Out-of-range indices are answered
// without a search. One request is worked on at a time.
// The result sits in an output register: a new request is taken while the
// previous result still waits, and the engine only holds when it needs to
// write the next result into a register that is still full.
// Reset clears the sequencer and the output valid; no state lives between
// requests.
module trial_division_prime_engine #(
	parameter int VALUE_BITS = tdpe_pkg::VALUE_BITS_DEF,
	parameter int MAX_INDEX  = tdpe_pkg::MAX_INDEX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tdpe_req_if.sink   req,
	tdpe_rsp_if.source rsp
);

	localparam int VB   = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
	localparam int SQ_W = 2 * VB;
	localparam int FW   = (MAX_INDEX > 1) ? $clog2(MAX_INDEX + 1) : 1;
	localparam int FD_W = tdpe_pkg::FIELD_W;

	tdpe_pkg::step_t       step_q;
	tdpe_pkg::uword_t      uw;
	tdpe_pkg::mod_status_t mod_st;

	logic            kind_q;
	logic [FD_W-1:0] opnd_q;
	logic [VB-1:0]   cand_q;
	logic [VB-1:0]   div_q;
	logic [SQ_W-1:0] sq_q;
	logic [FW-1:0]   found_q;

	logic            rsp_valid_q;
	logic            flag_q;
	logic [FD_W-1:0] value_q;
	logic            too_large_q;

	logic beat_in;
	logic stall;
	logic cond_hit;
	logic go;

	assign uw      = tdpe_pkg::ucode(step_q);
	assign beat_in = req.valid && req.ready;
	assign stall   = (uw.emit != tdpe_pkg::E_NONE) && rsp_valid_q && !rsp.ready;
	assign go      = !stall;

	always_comb begin
		unique case (uw.cond)
			tdpe_pkg::C_NEVER:    cond_hit = 1'b0;
			tdpe_pkg::C_ALWAYS:   cond_hit = 1'b1;
			tdpe_pkg::C_NO_BEAT:  cond_hit = !beat_in;
			tdpe_pkg::C_KIND1:    cond_hit = kind_q;
			tdpe_pkg::C_LT2:      cond_hit = (cand_q < VB'(2));
			tdpe_pkg::C_EQ2:      cond_hit = (cand_q == VB'(2));
			tdpe_pkg::C_EVEN:     cond_hit = !cand_q[0];
			tdpe_pkg::C_SQ_GT:    cond_hit = (sq_q > SQ_W'(cand_q));
			tdpe_pkg::C_MOD_BUSY: cond_hit = mod_st.busy;
			tdpe_pkg::C_REM_ZERO: cond_hit = mod_st.rem_zero;
			tdpe_pkg::C_IDX_BAD:  cond_hit = (opnd_q > FD_W'(MAX_INDEX));
			tdpe_pkg::C_IDX_ZERO: cond_hit = (opnd_q == '0);
			tdpe_pkg::C_FOUND_EQ: cond_hit = (FD_W'(found_q) == opnd_q);
			tdpe_pkg::C_AT_LIMIT: cond_hit = &cand_q[VB-1:1];
			default:              cond_hit = 1'b0;
		endcase
	end

	assign req.ready = uw.accept;

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= tdpe_pkg::S_WAIT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (go && (uw.emit != tdpe_pkg::E_NONE)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (go) begin
				if (cond_hit) begin
					step_q <= uw.target;
				end else begin
					step_q <= step_q + tdpe_pkg::step_t'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (uw.accept && beat_in) begin
			kind_q <= req.kind;
			opnd_q <= req.operand_value;
			cand_q <= req.operand_value[VB-1:0];
		end
		if (uw.ld_cand3) begin
			cand_q  <= VB'(3);
			found_q <= FW'(1);
		end
		if (uw.next_cand) begin
			cand_q <= cand_q + VB'(2);
		end
		if (uw.inc_found) begin
			found_q <= found_q + FW'(1);
		end
		if (uw.init_div) begin
			div_q <= VB'(3);
			sq_q  <= SQ_W'(9);
		end
		if (uw.next_div) begin
			// (d + 2)^2 = d^2 + 4d + 4
			div_q <= div_q + VB'(2);
			sq_q  <= sq_q + (SQ_W'(div_q) << 2) + SQ_W'(4);
		end
		if (go) begin
			unique case (uw.emit)
				tdpe_pkg::E_NONE: begin
				end
				tdpe_pkg::E_TEST_PASS: begin
					flag_q      <= 1'b1;
					value_q     <= FD_W'(cand_q);
					too_large_q <= 1'b0;
				end
				tdpe_pkg::E_TEST_FAIL: begin
					flag_q      <= 1'b0;
					value_q     <= FD_W'(cand_q);
					too_large_q <= 1'b0;
				end
				tdpe_pkg::E_NTH: begin
					flag_q      <= 1'b1;
					value_q     <= FD_W'(cand_q);
					too_large_q <= 1'b0;
				end
				tdpe_pkg::E_TWO: begin
					flag_q      <= 1'b1;
					value_q     <= FD_W'(2);
					too_large_q <= 1'b0;
				end
				tdpe_pkg::E_BAD: begin
					flag_q      <= 1'b1;
					value_q     <= '0;
					too_large_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	tdpe_mod_unit #(
		.W(VB)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (uw.start_mod),
		.dividend (cand_q),
		.divisor  (div_q),
		.status   (mod_st)
	);

	assign rsp.valid           = rsp_valid_q;
	assign rsp.is_prime_flag   = flag_q;
	assign rsp.prime_value     = value_q;
	assign rsp.index_too_large = too_large_q;

endmodule

/* rtl/core/tdpe_mod_unit.sv */
`timescale 1ns / 1ps

module tdpe_mod_unit #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor,
	output tdpe_pkg::mod_status_t status
);

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvd_q;
	logic [W-1:0]     dsr_q;
	logic [W:0]       trial;
	logic [W:0]       diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= trial[W-1:0];
			end
		end
	end

	assign status.busy     = busy_q;
	assign status.rem_zero = (rem_q == '0);

endmodule

/* bench/trial_division_prime_engine_test.sv */
`timescale 1ns / 1ps

module trial_division_prime_engine_test;

	localparam int VALUE_BITS      = tdpe_pkg::VALUE_BITS_DEF;
	localparam int MAX_INDEX       = tdpe_pkg::MAX_INDEX_DEF;
	localparam int FIELD_W         = tdpe_pkg::FIELD_W;
	localparam int VB              = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
	localparam int HALF_PERIOD     = 5;
	localparam int QUIET_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 64;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int CHEAP_TRIES     = 64;
	localparam int REPORT_LIMIT    = 10;

	localparam logic K_TEST = 1'b0;
	localparam logic K_NTH  = 1'b1;

	typedef struct packed {
		logic               flag;
		logic [FIELD_W-1:0] value;
		logic               over;
	} answer_t;

	typedef struct packed {
		logic               kind;
		logic [FIELD_W-1:0] operand;
		logic               known;
		answer_t            answer;
	} row_t;

	// known answers only where they are obvious, the rest go through the predictor
	localparam row_t DIRECTED [23] = '{
		'{K_TEST, 32'd0,          1'b1, '{1'b0, 32'd0, 1'b0}},
		'{K_TEST, 32'd1,          1'b1, '{1'b0, 32'd1, 1'b0}},
		'{K_TEST, 32'd2,          1'b1, '{1'b1, 32'd2, 1'b0}},
		'{K_TEST, 32'd3,          1'b1, '{1'b1, 32'd3, 1'b0}},
		'{K_TEST, 32'd4,          1'b1, '{1'b0, 32'd4, 1'b0}},
		'{K_TEST, 32'd9,          1'b0, '0},
		'{K_TEST, 32'd25,         1'b0, '0},
		'{K_TEST, 32'd65521,      1'b0, '0},
		'{K_TEST, 32'd1048573,    1'b0, '0},
		'{K_TEST, 32'hFFFF_FFFF,  1'b0, '0},
		'{K_TEST, 32'hFFFF_FFFE,  1'b1, '{1'b0, 32'hFFFF_FFFE, 1'b0}},
		'{K_TEST, 32'h8000_0000,  1'b1, '{1'b0, 32'h8000_0000, 1'b0}},
		'{K_TEST, 32'h8000_0001,  1'b0, '0},
		'{K_TEST, 32'h5555_5555,  1'b0, '0},
		'{K_TEST, 32'hAAAA_AAAA,  1'b1, '{1'b0, 32'hAAAA_AAAA, 1'b0}},
		'{K_NTH,  32'd0,          1'b1, '{1'b1, 32'd2, 1'b0}},
		'{K_NTH,  32'd1,          1'b0, '0},
		'{K_NTH,  32'd2,          1'b0, '0},
		'{K_NTH,  32'd9,          1'b0, '0},
		'{K_NTH,  32'd30,         1'b0, '0},
		'{K_NTH,  32'(MAX_INDEX + 1), 1'b1, '{1'b1, 32'd0, 1'b1}},
		'{K_NTH,  32'hFFFF_FFFF,  1'b1, '{1'b1, 32'd0, 1'b1}},
		'{K_NTH,  32'h8000_0000,  1'b1, '{1'b1, 32'd0, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_off_pending = 1'b0;
	int unsigned faults = 0;

	answer_t answers_due [$];

	tdpe_req_if req_ch ();
	tdpe_rsp_if rsp_ch ();

	trial_division_prime_engine #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_INDEX (MAX_INDEX)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic bit trial_divide(input logic [63:0] v, output int unsigned tries);
		logic [63:0] d;
		tries = 0;
		if (v < 64'd2) return 1'b0;
		if (v == 64'd2) return 1'b1;
		if (!v[0]) return 1'b0;
		for (d = 64'd3; d <= v / d; d += 64'd2) begin
			tries++;
			if (v % d == 64'd0) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic answer_t prime_answer(input logic kind, input logic [FIELD_W-1:0] operand);
		answer_t     a;
		logic [63:0] limit;
		logic [63:0] cand;
		logic [63:0] found;
		int unsigned tries;
		limit = (64'd1 << VB) - 64'd1;
		if (kind == K_TEST) begin
			a.value = FIELD_W'({32'd0, operand} & limit);
			a.flag  = trial_divide({32'd0, a.value}, tries);
			a.over  = 1'b0;
			return a;
		end
		a.flag  = 1'b1;
		a.value = '0;
		a.over  = 1'b1;
		if (operand > MAX_INDEX) return a;
		if (operand == '0) begin
			if (limit >= 64'd2) begin
				a.value = FIELD_W'(2);
				a.over  = 1'b0;
			end
			return a;
		end
		found = 64'd1;
		cand  = 64'd3;
		while (cand <= limit) begin
			if (trial_divide(cand, tries)) begin
				if (found == operand) begin
					a.value = FIELD_W'(cand);
					a.over  = 1'b0;
					return a;
				end
				found++;
			end
			if (limit - cand < 64'd2) break;
			cand += 64'd2;
		end
		return a;
	endfunction

	task automatic offer(input logic kind, input logic [FIELD_W-1:0] operand, input answer_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.kind          <= kind;
		req_ch.operand_value <= operand;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		answers_due.push_back(want);
	endtask

	// result side: checks every beat, stalls at random, long hold-off on request
	initial begin
		answer_t     got;
		answer_t     want;
		int unsigned hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.is_prime_flag, rsp_ch.prime_value, rsp_ch.index_too_large};
				if (answers_due.size() == 0) begin
					if (faults < REPORT_LIMIT)
						$display("unexpected result beat: flag=%0b value=%0d over=%0b",
							got.flag, got.value, got.over);
					faults++;
				end else begin
					want = answers_due.pop_front();
					if (got !== want) begin
						if (faults < REPORT_LIMIT)
							$display({"mismatch: expected flag=%0b value=%0d over=%0b, ",
								"got flag=%0b value=%0d over=%0b"},
								want.flag, want.value, want.over,
								got.flag, got.value, got.over);
						faults++;
					end
				end
			end
			if (hold_off_pending) begin
				hold_left        = HOLD_OFF_CYCLES;
				hold_off_pending = 1'b0;
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** trial_division_prime_engine: FAILED **");
		$finish;
	end

	initial begin
		logic               kind;
		logic [FIELD_W-1:0] operand;
		int unsigned        tries;
		int unsigned        pick;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.kind          <= K_TEST;
		req_ch.operand_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			offer(DIRECTED[i].kind, DIRECTED[i].operand,
				DIRECTED[i].known ? DIRECTED[i].answer
					: prime_answer(DIRECTED[i].kind, DIRECTED[i].operand));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct    = 0;
					recv_stall_pct   = 0;
					hold_off_pending = 1'b1;
				end
				1: begin
					send_idle_pct  = 57;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 57;
				end
				default: begin
					send_idle_pct  = 35;
					recv_stall_pct = 35;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					// full width, but only values with a small factor keep the run short
					kind = K_TEST;
					do begin
						operand = $urandom;
						void'(trial_divide({32'd0, operand}, tries));
					end while (tries > CHEAP_TRIES);
				end else if (pick < 65) begin
					kind    = K_TEST;
					operand = $urandom_range(4095, 0);
				end else if (pick < 85) begin
					kind    = K_NTH;
					operand = $urandom_range(24, 0);
				end else begin
					kind    = K_NTH;
					operand = $urandom_range(32'hFFFF_FFFF, MAX_INDEX + 1);
				end
				offer(kind, operand, prime_answer(kind, operand));
			end
		end
		req_ch.valid <= 1'b0;

		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (faults == 0 && answers_due.size() == 0)
			$display("** trial_division_prime_engine: PASSED **");
		else
			$display("** trial_division_prime_engine: FAILED **");
		$finish;
	end

endmodule
